// File: rtl/cfa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the complementary attitude filter.
// No dependencies.
package cfa_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int ATAN_TAB_LEN        = 24;

    localparam int FIELD_W  = 16;
    localparam int ANGLE_W  = 32;
    localparam int DIV_W    = 48;
    localparam int DIVR_W   = 10;
    localparam int WIDE_W   = 52;
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 18;
    localparam int CFG_IDX_W = 3;

    localparam int GYRO_SCALE = 131;
    localparam int MS_PER_S   = 1000;
    localparam logic [FIELD_W-1:0] WEIGHT_RESET = 16'd65274;

    // ceil(2^shift / divisor); exact floor quotient for 26-bit partial dividends
    localparam int RECIP_W       = 27;
    localparam int RECIP_SH_GYRO = 34;
    localparam int RECIP_SH_MS   = 36;
    localparam logic [RECIP_W-1:0] RECIP_GYRO = 27'd131144040;
    localparam logic [RECIP_W-1:0] RECIP_MS   = 27'd68719477;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACC_ROLL_OFF  = 3'd0,
        CFG_ACC_PITCH_OFF = 3'd1,
        CFG_GYRO_X_OFF    = 3'd2,
        CFG_GYRO_Y_OFF    = 3'd3,
        CFG_GYRO_Z_OFF    = 3'd4,
        CFG_GYRO_WEIGHT   = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        DIVISOR_GYRO = 1'b0,
        DIVISOR_MS   = 1'b1
    } divisor_sel_t;

    // atan(2^-i) in degrees, scaled by 2^24
    function automatic logic signed [32:0] atan_deg(input logic [4:0] i);
        logic signed [32:0] v;
        case (i)
            5'd0:    v = 33'sd754974720;
            5'd1:    v = 33'sd445687602;
            5'd2:    v = 33'sd235489088;
            5'd3:    v = 33'sd119537938;
            5'd4:    v = 33'sd60000934;
            5'd5:    v = 33'sd30029717;
            5'd6:    v = 33'sd15018523;
            5'd7:    v = 33'sd7509720;
            5'd8:    v = 33'sd3754917;
            5'd9:    v = 33'sd1877466;
            5'd10:   v = 33'sd938734;
            5'd11:   v = 33'sd469367;
            5'd12:   v = 33'sd234684;
            5'd13:   v = 33'sd117342;
            5'd14:   v = 33'sd58671;
            5'd15:   v = 33'sd29335;
            5'd16:   v = 33'sd14668;
            5'd17:   v = 33'sd7334;
            5'd18:   v = 33'sd3667;
            5'd19:   v = 33'sd1833;
            5'd20:   v = 33'sd917;
            5'd21:   v = 33'sd458;
            5'd22:   v = 33'sd229;
            5'd23:   v = 33'sd115;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [ANGLE_W-1:0] r;
        if (v > WIDE_W'(64'sd2147483647))
            r = 32'sh7fffffff;
        else if (v < -WIDE_W'(64'sd2147483648))
            r = 32'sh80000000;
        else
            r = v[ANGLE_W-1:0];
        return r;
    endfunction

endpackage

// File: rtl/cfa_div.sv
`timescale 1ns / 1ps
// Divider by a selectable constant: 16-bit digits by reciprocal multiplication,
// each digit in a quotient phase, then a remainder phase. Depends on cfa_pkg.
module cfa_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  cfa_pkg::divisor_sel_t     sel,
    input  logic [cfa_pkg::DIV_W-1:0] dividend,
    output logic                      done,
    output logic [cfa_pkg::DIV_W-1:0] quotient
);
    import cfa_pkg::*;

    localparam int CHUNK_W = 16;
    localparam int CHUNKS  = DIV_W / CHUNK_W;
    localparam int T_W     = DIVR_W + CHUNK_W;
    localparam int P_W     = T_W + RECIP_W;
    localparam int CNT_W   = $clog2(CHUNKS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    divisor_sel_t       sel_reg, sel_next;
    logic [DIVR_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]   src_reg, src_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [CHUNK_W-1:0] qd_reg, qd_next;

    logic [T_W-1:0]     t;
    logic [RECIP_W-1:0] recip;
    logic [DIVR_W-1:0]  dvs;
    logic [P_W-1:0]     prod;
    logic [CHUNK_W-1:0] q_digit;
    logic [T_W-1:0]     back;

    always_comb
    begin
        t       = {rem_reg, src_reg[DIV_W-1 -: CHUNK_W]};
        recip   = (sel_reg == DIVISOR_MS) ? RECIP_MS : RECIP_GYRO;
        dvs     = (sel_reg == DIVISOR_MS) ? DIVR_W'(MS_PER_S) : DIVR_W'(GYRO_SCALE);
        prod    = t * recip;
        q_digit = (sel_reg == DIVISOR_MS) ? prod[RECIP_SH_MS +: CHUNK_W]
                                          : prod[RECIP_SH_GYRO +: CHUNK_W];
        back    = T_W'(qd_reg) * T_W'(dvs);

        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        rem_next   = rem_reg;
        src_next   = src_reg;
        quo_next   = quo_reg;
        qd_next    = qd_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = '0;
            sel_next   = sel;
            rem_next   = '0;
            src_next   = dividend;
            quo_next   = '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                qd_next    = q_digit;
                phase_next = 1'b1;
            end
            else
            begin
                rem_next   = DIVR_W'(t - back);
                quo_next   = {quo_reg[DIV_W-CHUNK_W-1:0], qd_reg};
                src_next   = {src_reg[DIV_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
                phase_next = 1'b0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CHUNKS - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        rem_reg <= rem_next;
        src_reg <= src_next;
        quo_reg <= quo_next;
        qd_reg  <= qd_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/cfa_atan.sv
`timescale 1ns / 1ps
// Accelerometer angle unit: digit-serial square root, then vectoring CORDIC in degrees.
// Depends on cfa_pkg.
module cfa_atan #(
    parameter int CORDIC_STEPS    = cfa_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = cfa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [16:0] num,
    input  logic [31:0]        den_sq,
    output logic               done,
    output logic signed [32:0] angle
);
    import cfa_pkg::*;

    localparam int ITER     = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
    localparam int SQ_STEPS = 30;
    localparam int SRC_W    = 60;

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_SQRT = 3'b010,
        A_ROT  = 3'b100
    } atan_state_t;

    atan_state_t        state_reg, state_next;
    logic               done_reg, done_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [31:0]        rem_reg, rem_next;
    logic [29:0]        root_reg, root_next;
    logic signed [16:0] num_reg, num_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic               zero_reg, zero_next;

    logic [33:0]        t, trial;
    logic signed [33:0] xs, ys;
    logic signed [32:0] z_rnd;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        src_next   = src_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        num_next   = num_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        t          = {rem_reg, src_reg[SRC_W-1 -: 2]};
        trial      = {2'b00, root_reg, 2'b01};
        xs         = x_reg >>> cnt_reg;
        ys         = y_reg >>> cnt_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    src_next   = {den_sq, 28'd0};
                    rem_next   = '0;
                    root_next  = '0;
                    num_next   = num;
                    cnt_next   = '0;
                    state_next = A_SQRT;
                end
            end
            A_SQRT:
            begin
                if (t >= trial)
                begin
                    rem_next  = 32'(t - trial);
                    root_next = {root_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_next  = t[31:0];
                    root_next = {root_reg[28:0], 1'b0};
                end
                src_next = {src_reg[SRC_W-3:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(SQ_STEPS - 1))
                begin
                    x_next     = {3'b000, root_next, 1'b0} >>> 1;
                    y_next     = 34'(num_reg) <<< 14;
                    z_next     = '0;
                    zero_next  = (root_next == '0) && (num_reg == '0);
                    cnt_next   = '0;
                    state_next = A_ROT;
                end
            end
            A_ROT:
            begin
                if (!y_reg[33])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_deg(cnt_reg);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_deg(cnt_reg);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(ITER - 1))
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default:
                state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        num_reg  <= num_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    assign z_rnd = z_reg + (33'sd1 <<< (23 - ANGLE_FRAC_BITS));
    assign angle = zero_reg ? 33'sd0 : (z_rnd >>> (24 - ANGLE_FRAC_BITS));
    assign done  = done_reg;

endmodule

// File: rtl/imu_complementary_attitude_filter_core.sv
`timescale 1ns / 1ps
// Top level: sequencer, shared multiplier, filter state and stream ports.
// Depends on cfa_pkg, cfa_div, cfa_atan.
//
//  channel  | dir | signals                          | content
//  s_axis   | in  | s_tvalid s_tready s_tdata[111:0] | one sensor sample
//  m_axis   | out | m_tvalid m_tready m_tdata[95:0]  | roll, pitch, yaw
//  cfg      | in  | cfg_we cfg_index cfg_data        | offsets and blend weight
//
// Per item the square root and CORDIC iterations run for each accelerometer angle, and
// two constant divisions (by 16-bit digits) run for each gyro axis.
// s_tready is high only while the sequencer is idle; one item in flight.
// A finished result waits in the output register; the next item may be taken meanwhile.
// Reset clears the estimates and loads the register defaults.
module imu_complementary_attitude_filter_core #(
    parameter int CORDIC_STEPS    = cfa_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = cfa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms
    input  logic [111:0]                  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // roll, pitch, yaw
    output logic [95:0]                   m_tdata,
    input  logic                          cfg_we,
    input  logic [cfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfa_pkg::FIELD_W-1:0]   cfg_data
);
    import cfa_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_SQ_A = 15'h0002,
        S_SQ_B = 15'h0004,
        S_SQ_C = 15'h0008,
        S_ATAN = 15'h0010,
        S_GD1S = 15'h0020,
        S_GD1W = 15'h0040,
        S_GMUL = 15'h0080,
        S_GD2S = 15'h0100,
        S_GD2W = 15'h0200,
        S_GINT = 15'h0400,
        S_BM_A = 15'h0800,
        S_BM_B = 15'h1000,
        S_BM_C = 15'h2000,
        S_OUT  = 15'h4000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    logic [FIELD_W-1:0] roff_reg, poff_reg, gxoff_reg, gyoff_reg, gzoff_reg, w_reg;

    logic signed [FIELD_W-1:0] ax_reg, ay_reg, az_reg, rx_reg, ry_reg, rz_reg;
    logic [FIELD_W-1:0]        ms_reg;

    logic signed [WIDE_W-1:0]  prod_reg, acc_reg;
    logic signed [MUL_A_W-1:0] r_reg, r_next;
    logic signed [MUL_A_W-1:0] aang_reg [2];
    logic signed [ANGLE_W-1:0] g_reg [2];
    logic signed [37:0]        inc_reg, inc_next;
    logic                      neg_reg, neg_next;
    logic signed [ANGLE_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                      ov_reg;
    logic [95:0]               od_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [WIDE_W-1:0]  mul_p;

    logic                      atan_start, atan_done;
    logic signed [16:0]        atan_num;
    logic [31:0]               atan_den;
    logic signed [32:0]        atan_ang;

    logic                      div_start, div_done;
    divisor_sel_t              div_sel;
    logic [DIV_W-1:0]          div_dvd, div_quo;

    logic signed [FIELD_W-1:0] rate_sel;
    logic [FIELD_W-1:0]        goff_sel, aoff_sel;
    logic signed [16:0]        rate_mag;
    logic signed [WIDE_W-1:0]  prod_mag;
    logic signed [MUL_A_W-1:0] q_signed;
    logic signed [ANGLE_W-1:0] gest_sel;
    logic signed [WIDE_W-1:0]  int_sum, blend_sum;
    logic signed [ANGLE_W-1:0] int_sat, blend_sat;
    logic                      accept;

    function automatic logic signed [MUL_A_W-1:0] off_sh(input logic [FIELD_W-1:0] o);
        return MUL_A_W'($signed(o)) <<< (ANGLE_FRAC_BITS - 8);
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                rate_sel = rx_reg;
                goff_sel = gxoff_reg;
                gest_sel = roll_reg;
            end
            2'd1:
            begin
                rate_sel = ry_reg;
                goff_sel = gyoff_reg;
                gest_sel = pitch_reg;
            end
            default:
            begin
                rate_sel = rz_reg;
                goff_sel = gzoff_reg;
                gest_sel = yaw_reg;
            end
        endcase
        aoff_sel = idx_reg[0] ? poff_reg : roff_reg;
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = MUL_A_W'(az_reg);
        mul_b = MUL_B_W'(az_reg);
        case (state_reg)
            S_SQ_A:
            begin
                mul_a = idx_reg[0] ? MUL_A_W'(ay_reg) : MUL_A_W'(ax_reg);
                mul_b = idx_reg[0] ? MUL_B_W'(ay_reg) : MUL_B_W'(ax_reg);
            end
            S_GMUL:
            begin
                mul_a = r_reg;
                mul_b = $signed({2'b00, ms_reg});
            end
            S_BM_A:
            begin
                mul_a = MUL_A_W'(g_reg[idx_reg[0]]);
                mul_b = $signed({2'b00, w_reg});
            end
            S_BM_B:
            begin
                mul_a = aang_reg[idx_reg[0]];
                mul_b = $signed(18'h10000 - {2'b00, w_reg});
            end
            default:
            begin
                mul_a = MUL_A_W'(az_reg);
                mul_b = MUL_B_W'(az_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign atan_num = idx_reg[0] ? -17'(ax_reg) : 17'(ay_reg);
    assign atan_den = acc_reg[31:0] + prod_reg[31:0];

    assign rate_mag = rate_sel[15] ? -17'(rate_sel) : 17'(rate_sel);
    assign prod_mag = prod_reg[WIDE_W-1] ? -prod_reg : prod_reg;
    assign q_signed = neg_reg ? -MUL_A_W'(div_quo[MUL_A_W-1:0]) : MUL_A_W'(div_quo[MUL_A_W-1:0]);

    always_comb
    begin
        div_start = (state_reg == S_GD1S) || (state_reg == S_GD2S);
        div_sel   = (state_reg == S_GD2S) ? DIVISOR_MS : DIVISOR_GYRO;
        if (state_reg == S_GD2S)
            div_dvd = DIV_W'(prod_mag) + DIV_W'(MS_PER_S / 2);
        else
            div_dvd = (DIV_W'(rate_mag) << ANGLE_FRAC_BITS) + DIV_W'(GYRO_SCALE / 2);
    end

    assign int_sum   = WIDE_W'(gest_sel) + WIDE_W'(inc_reg);
    assign int_sat   = sat32(int_sum);
    assign blend_sum = (acc_reg + prod_reg + WIDE_W'(32768)) >>> 16;
    assign blend_sat = sat32(blend_sum);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        r_next     = r_reg;
        inc_next   = inc_reg;
        neg_next   = neg_reg;
        atan_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    state_next = S_SQ_A;
                end
            end
            S_SQ_A:
                state_next = S_SQ_B;
            S_SQ_B:
                state_next = S_SQ_C;
            S_SQ_C:
            begin
                atan_start = 1'b1;
                state_next = S_ATAN;
            end
            S_ATAN:
            begin
                if (atan_done)
                begin
                    if (idx_reg[0])
                    begin
                        idx_next   = '0;
                        state_next = S_GD1S;
                    end
                    else
                    begin
                        idx_next   = 2'd1;
                        state_next = S_SQ_A;
                    end
                end
            end
            S_GD1S:
            begin
                neg_next   = rate_sel[15];
                state_next = S_GD1W;
            end
            S_GD1W:
            begin
                if (div_done)
                begin
                    r_next     = q_signed - off_sh(goff_sel);
                    state_next = S_GMUL;
                end
            end
            S_GMUL:
                state_next = S_GD2S;
            S_GD2S:
            begin
                neg_next   = prod_reg[WIDE_W-1];
                state_next = S_GD2W;
            end
            S_GD2W:
            begin
                if (div_done)
                begin
                    inc_next   = neg_reg ? -38'(div_quo[37:0]) : 38'(div_quo[37:0]);
                    state_next = S_GINT;
                end
            end
            S_GINT:
            begin
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = S_BM_A;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_GD1S;
                end
            end
            S_BM_A:
                state_next = S_BM_B;
            S_BM_B:
                state_next = S_BM_C;
            S_BM_C:
            begin
                if (idx_reg[0])
                    state_next = S_OUT;
                else
                begin
                    idx_next   = 2'd1;
                    state_next = S_BM_A;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            roff_reg  <= '0;
            poff_reg  <= '0;
            gxoff_reg <= '0;
            gyoff_reg <= '0;
            gzoff_reg <= '0;
            w_reg     <= WEIGHT_RESET;
            roll_reg  <= '0;
            pitch_reg <= '0;
            yaw_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACC_ROLL_OFF:  roff_reg  <= cfg_data;
                    CFG_ACC_PITCH_OFF: poff_reg  <= cfg_data;
                    CFG_GYRO_X_OFF:    gxoff_reg <= cfg_data;
                    CFG_GYRO_Y_OFF:    gyoff_reg <= cfg_data;
                    CFG_GYRO_Z_OFF:    gzoff_reg <= cfg_data;
                    CFG_GYRO_WEIGHT:   w_reg     <= cfg_data;
                    default:           ;
                endcase
            end
            if (state_reg == S_GINT && idx_reg == 2'd2)
                yaw_reg <= int_sat;
            if (state_reg == S_BM_C)
            begin
                if (idx_reg[0])
                    pitch_reg <= blend_sat;
                else
                    roll_reg <= blend_sat;
            end
            if (state_reg == S_OUT && (!ov_reg || m_tready))
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= s_tdata[15:0];
            ay_reg <= s_tdata[31:16];
            az_reg <= s_tdata[47:32];
            rx_reg <= s_tdata[63:48];
            ry_reg <= s_tdata[79:64];
            rz_reg <= s_tdata[95:80];
            ms_reg <= s_tdata[111:96];
        end
        prod_reg <= mul_p;
        if (state_reg == S_SQ_B || state_reg == S_BM_B)
            acc_reg <= prod_reg;
        r_reg   <= r_next;
        inc_reg <= inc_next;
        neg_reg <= neg_next;
        if (state_reg == S_ATAN && atan_done)
            aang_reg[idx_reg[0]] <= MUL_A_W'(atan_ang) - off_sh(aoff_sel);
        if (state_reg == S_GINT && idx_reg != 2'd2)
            g_reg[idx_reg[0]] <= int_sat;
        if (state_reg == S_OUT && (!ov_reg || m_tready))
            od_reg <= {yaw_reg, pitch_reg, roll_reg};
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    cfa_atan #(
        .CORDIC_STEPS   (CORDIC_STEPS),
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_atan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (atan_start),
        .num   (atan_num),
        .den_sq(atan_den),
        .done  (atan_done),
        .angle (atan_ang)
    );

    cfa_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .sel     (div_sel),
        .dividend(div_dvd),
        .done    (div_done),
        .quotient(div_quo)
    );

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_GD1W || state_reg == S_GD2W))
        else $error("divider finished outside a wait state");

    a_atan_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        atan_done |-> (state_reg == S_ATAN))
        else $error("angle unit finished outside its wait state");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result appeared without passing the output state");

endmodule
